// ----- hw/rtl/b64e_pkg.sv -----
package b64e_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 8;

    localparam logic [7:0] MIN_LINE    = 8'd14;
    localparam logic [7:0] LINE_RESET  = 8'd64;
    localparam logic [7:0] CHAR_NL     = 8'h0a;
    localparam logic [7:0] CHAR_PAD    = 8'h3d;

    localparam logic REG_LINE_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SYM,
        ST_PAD,
        ST_NL
    } t_state;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2b;
        end else begin
            return 8'h2f;
        end
    endfunction

endpackage

// ----- hw/rtl/b64e_rem.sv -----
module b64e_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [7:0]  o_rem
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_idx, n_idx;
    logic [31:0] r_quo, n_quo;
    logic [7:0]  r_rem, n_rem;
    logic [8:0]  trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_idx  = r_idx;
        n_quo  = r_quo;
        n_rem  = r_rem;
        trial  = {r_rem, r_quo[31]};
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = 5'd31;
            n_quo  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[30:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = 8'(trial - {1'b0, i_divisor});
            end else begin
                n_rem = trial[7:0];
            end
            n_idx = r_idx - 5'd1;
            if (r_idx == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hw/rtl/base64_block_stream_encoder.sv -----
// Base64 encoder with line wrap fed one cipher block per transfer. Each input transfer carries
// BLOCK_BYTES bytes in the low bits of tdata, most significant byte first; tuser marks the
// final block of a message, which pads any held-over partial group with '=' and ends with a
// newline. One character leaves per cycle through a registered output unless it is stalled;
// a new block is taken only once the output sequencer is back in idle. A write to line_length
// recomputes the line position with a bit-serial remainder unit and holds s_tready low until
// that unit is done.
module base64_block_stream_encoder #(
    parameter int unsigned BLOCK_BYTES = b64e_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] block
    input  logic        i_s_tuser,   // [0] flush
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_char
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import b64e_pkg::*;

    localparam int BLK_W    = 8 * BLOCK_BYTES;
    localparam int BUF_W    = 8 * (BLOCK_BYTES + 2);
    localparam int G_BASE   = BLOCK_BYTES / 3;
    localparam int R_BASE   = BLOCK_BYTES % 3;
    localparam int NSYM_MAX = 4 * ((BLOCK_BYTES + 2) / 3) + 3;
    localparam int NSYM_W   = $clog2(NSYM_MAX + 1);

    t_state              r_state, n_state;
    logic [BUF_W-1:0]    r_buf, n_buf;
    logic [NSYM_W-1:0]   r_nsym, n_nsym;
    logic [1:0]          r_npad, n_npad;
    logic                r_flush, n_flush;
    logic                r_nl_done, n_nl_done;
    logic [15:0]         r_carry, n_carry;
    logic [1:0]          r_carry_cnt, n_carry_cnt;
    logic [31:0]         r_cnt, n_cnt;
    logic [7:0]          r_col, n_col;
    logic [7:0]          r_line_length;
    logic [7:0]          r_len_eff;
    logic                r_rem_start;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_char, n_out_char;
    logic                r_out_last, n_out_last;

    logic                cfg_wr;
    logic                accept;
    logic                step;
    logic                rem_busy;
    logic                rem_done;
    logic [7:0]          rem_val;
    logic [2:0]          sum;
    logic                full;
    logic [1:0]          ccn;
    logic [NSYM_W-1:0]   nsym_full;
    logic [NSYM_W-1:0]   nsym_tail;
    logic [BUF_W-1:0]    cat;
    logic [31:0]         cnt_inc;
    logic [7:0]          col_inc;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_LENGTH) ? {24'd0, r_line_length} : 32'd0;

    assign o_s_tready = (r_state == ST_IDLE) && !r_rem_start && !rem_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign step       = !r_out_valid || i_m_tready;

    b64e_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_rem_start),
        .i_dividend (r_cnt),
        .i_divisor  (r_len_eff),
        .o_busy     (rem_busy),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    always_comb begin
        sum       = 3'(R_BASE) + {1'b0, r_carry_cnt};
        full      = (sum >= 3'd3);
        ccn       = full ? 2'(sum - 3'd3) : sum[1:0];
        nsym_full = NSYM_W'(4 * G_BASE) + (full ? NSYM_W'(4) : '0);
        nsym_tail = (i_s_tuser && ccn != 2'd0) ? NSYM_W'(ccn) + NSYM_W'(1) : '0;
        cat       = {r_carry, i_s_tdata[BLK_W-1:0]};
        cnt_inc   = r_cnt + 32'd1;
        col_inc   = r_col + 8'd1;

        n_state     = r_state;
        n_buf       = r_buf;
        n_nsym      = r_nsym;
        n_npad      = r_npad;
        n_flush     = r_flush;
        n_nl_done   = r_nl_done;
        n_carry     = r_carry;
        n_carry_cnt = r_carry_cnt;
        n_cnt       = r_cnt;
        n_col       = rem_done ? rem_val : r_col;
        n_out_valid = step ? 1'b0 : r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_nsym      = nsym_full + nsym_tail;
                    n_npad      = (i_s_tuser && ccn != 2'd0) ? 2'(3'd3 - {1'b0, ccn}) : 2'd0;
                    n_flush     = i_s_tuser;
                    n_nl_done   = 1'b0;
                    n_carry     = cat[15:0];
                    n_carry_cnt = i_s_tuser ? 2'd0 : ccn;
                    case (r_carry_cnt)
                        2'd0:    n_buf = cat << 16;
                        2'd1:    n_buf = cat << 8;
                        default: n_buf = cat;
                    endcase
                    if (nsym_full + nsym_tail != '0) begin
                        n_state = ST_SYM;
                    end else if (i_s_tuser) begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_SYM: begin
                if (step) begin
                    n_out_valid = 1'b1;
                    if (r_cnt != 32'd0 && r_col == 8'd0 && !r_nl_done) begin
                        n_out_char = CHAR_NL;
                        n_out_last = 1'b0;
                        n_nl_done  = 1'b1;
                    end else begin
                        n_out_char = b64_sym(r_buf[BUF_W-1 -: 6]);
                        n_out_last = (r_nsym == NSYM_W'(1)) && !r_flush;
                        n_buf      = r_buf << 6;
                        n_nl_done  = 1'b0;
                        n_nsym     = r_nsym - NSYM_W'(1);
                        n_cnt      = cnt_inc;
                        n_col      = (cnt_inc == 32'd0 || col_inc == r_len_eff) ? 8'd0 : col_inc;
                        if (r_nsym == NSYM_W'(1)) begin
                            if (!r_flush) begin
                                n_state = ST_IDLE;
                            end else if (r_npad != 2'd0) begin
                                n_state = ST_PAD;
                            end else begin
                                n_state = ST_NL;
                            end
                        end
                    end
                end
            end
            ST_PAD: begin
                if (step) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_PAD;
                    n_out_last  = 1'b0;
                    n_npad      = r_npad - 2'd1;
                    if (r_npad == 2'd1) begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_NL: begin
                if (step) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_NL;
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_carry_cnt   <= 2'd0;
            r_cnt         <= 32'd0;
            r_col         <= 8'd0;
            r_line_length <= LINE_RESET;
            r_len_eff     <= LINE_RESET;
            r_rem_start   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_nl_done     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_carry_cnt <= n_carry_cnt;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_rem_start <= cfg_wr;
            r_out_valid <= n_out_valid;
            r_nl_done   <= n_nl_done;
            if (cfg_wr) begin
                r_line_length <= pwdata[7:0];
                r_len_eff     <= (pwdata[7:0] < MIN_LINE) ? MIN_LINE : pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_nsym     <= n_nsym;
        r_npad     <= n_npad;
        r_flush    <= n_flush;
        r_carry    <= n_carry;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- hw/rtl/b64e_chk.sv -----
module b64e_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    import b64e_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LENGTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (paddr[2] != REG_LINE_LENGTH) || (prdata[7:0] == $past(pwdata[7:0])))
        else $error("line_length readback mismatch");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !o_s_tready)
        else $error("input ready right after line_length write");

    a_pad_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata == CHAR_PAD) |-> !o_m_tlast)
        else $error("padding marked as final character");

endmodule

bind base64_block_stream_encoder b64e_chk u_b64e_chk (.*);
